FILE: src/swmm_pkg.sv
// shared constants and types for the sliding window min / max / mean block
// no dependencies
package swmm_pkg;
    localparam int WINDOW_DEPTH = 256;
    localparam int RING_SLOTS   = WINDOW_DEPTH + 1;
    localparam int POS_W        = $clog2(RING_SLOTS);
    localparam int CNT_W        = $clog2(RING_SLOTS + 1);
    localparam int SAMPLE_W     = 32;
    localparam int SUM_W        = 41;
    localparam int LEN_W        = 9;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd200;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
endpackage

FILE: src/swmm_cell.sv
// one storage cell of the sample chain, passes its sample on each shift
// depends on swmm_pkg
module swmm_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  swmm_pkg::t_sample i_d,
    output swmm_pkg::t_sample o_q
);
    import swmm_pkg::*;

    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

FILE: src/swmm_div.sv
// iterative signed divide of the window sum by the sample count, one bit a cycle
// depends on swmm_pkg
module swmm_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  swmm_pkg::t_sum         i_dividend,
    input  logic [swmm_pkg::CNT_W-1:0] i_divisor,
    output logic                   o_done,
    output swmm_pkg::t_sample      o_quot
);
    import swmm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W:0]     r_rem;
    logic [SUM_W-1:0]   r_mq;
    logic               r_neg;
    logic [CNT_W-1:0]   r_div;
    logic [CNT_W:0]     n_rem;
    logic               n_bit;
    logic [SUM_W-1:0]   w_q;

    always_comb begin
        n_rem = {r_rem[CNT_W-1:0], r_mq[SUM_W-1]};
        n_bit = (n_rem >= {1'b0, r_div});
        if (n_bit) begin
            n_rem = n_rem - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // pulse after the last quotient bit
            r_done <= !i_start && r_busy && (r_step == STEP_W'(SUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_neg  <= i_dividend[SUM_W-1];
                r_mq   <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_mq  <= {r_mq[SUM_W-2:0], n_bit};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign w_q    = r_neg ? (~r_mq + 1'b1) : r_mq;
    assign o_quot = w_q[SAMPLE_W-1:0];
    assign o_done = r_done;
endmodule

FILE: src/sliding_window_min_max_mean.sv
// sliding window minimum, maximum, spread and mean over signed q16.16 samples
// depends on swmm_pkg, swmm_cell, swmm_div
//
// usage:
//  - input channel (i_in_valid / o_in_ready) moves one sample per transfer
//  - output channel (o_out_valid / i_out_ready) moves one result per input
//    transfer: accepted flag, mean, minimum, maximum, spread and count
//  - config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//    enable, track_extremes and window_length; write only while idle
//  - an enabled sample takes a load step, then a full rotate pass
//    around the cell chain (evict, rescan), then the mean divider and
//    the handoff to the output register
//  - a disabled sample skips the pass and goes straight to the divider
//  - the pass covers the ring of 257 cells, and the mean comes from the
//    one-bit-per-cycle divider
//  - one sample in work at a time; a finished result sits in the output
//    register so the next sample can be taken while the receiver stalls
//  - reset (synchronous, active low) empties the window, sets the extremes
//    to their empty values, and loads the register defaults
//  - cell contents are not reset; only cells that hold samples are used
module sliding_window_min_max_mean (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [31:0]             i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_accepted,
    output logic signed [31:0]             o_mean,
    output logic signed [31:0]             o_minimum,
    output logic signed [31:0]             o_maximum,
    output logic [31:0]                    o_spread,
    output logic [8:0]                     o_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swmm_pkg::LEN_W-1:0]     i_cfg_data
);
    import swmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROT, ST_DIV, ST_WAIT, ST_DONE
    } t_state;

    localparam t_sample MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    t_state r_state;

    // config registers
    logic             r_enable;
    logic             r_track;
    logic [LEN_W-1:0] r_len_cfg;

    // window state
    logic [CNT_W-1:0] r_held;
    t_sum             r_sum;
    t_sample          r_min;
    t_sample          r_max;
    logic [31:0]      r_spread;

    // pass state
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_h;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_keep;
    t_sample          r_lo;
    t_sample          r_hi;
    logic             r_redo_min;
    logic             r_redo_max;
    logic             r_acc;
    t_sample          r_mean;

    // output register
    logic             r_out_valid;
    logic             r_o_acc;
    t_sample          r_o_mean;
    t_sample          r_o_min;
    t_sample          r_o_max;
    logic [31:0]      r_o_spread;
    logic [8:0]       r_o_count;

    // cell chain
    t_sample          w_cell [RING_SLOTS];
    t_sample          w_head;
    logic             w_shift;
    t_sample          w_tail;

    logic             w_in_xfer;
    logic [CNT_W-1:0] w_eff_len;
    logic [CNT_W-1:0] w_h_new;
    t_sum             w_x;
    t_sample          n_max_in;
    t_sample          n_min_in;

    logic             w_evict;
    logic             w_retain;
    t_sample          n_lo;
    t_sample          n_hi;
    logic             n_redo_min;
    logic             n_redo_max;
    t_sample          n_min;
    t_sample          n_max;
    logic signed [32:0] w_diff;

    logic             w_div_done;
    t_sample          w_quot;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_shift   = (w_in_xfer && r_enable) || (r_state == ST_ROT);
    assign w_head    = (r_state == ST_IDLE) ? i_sample : w_tail;
    assign w_tail    = w_cell[RING_SLOTS-1];

    for (genvar k = 0; k < RING_SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            swmm_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_d    (w_head),
                .o_q    (w_cell[k])
            );
        end else begin : g_next
            swmm_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_d    (w_cell[k-1]),
                .o_q    (w_cell[k])
            );
        end
    end

    // zero means one, clamp to the window depth
    always_comb begin
        if (r_len_cfg == '0) begin
            w_eff_len = CNT_W'(1);
        end else if (CNT_W'(r_len_cfg) > CNT_W'(WINDOW_DEPTH)) begin
            w_eff_len = CNT_W'(WINDOW_DEPTH);
        end else begin
            w_eff_len = CNT_W'(r_len_cfg);
        end
    end

    // load step: new sample updates sum, and extremes when tracking
    assign w_h_new  = (r_held < CNT_W'(RING_SLOTS)) ? r_held + 1'b1 : r_held;
    assign w_x      = SUM_W'(i_sample);
    assign n_max_in = (r_track && i_sample > r_max) ? i_sample : r_max;
    assign n_min_in = (r_track && i_sample < r_min) ? i_sample : r_min;

    // rotate step: tail cell holds position r_pos, oldest first
    always_comb begin
        w_evict    = (CNT_W'(r_pos) >= r_len) && (CNT_W'(r_pos) < r_h);
        w_retain   = CNT_W'(r_pos) < r_keep;
        n_lo       = (w_retain && w_tail < r_lo) ? w_tail : r_lo;
        n_hi       = (w_retain && w_tail > r_hi) ? w_tail : r_hi;
        n_redo_min = r_redo_min || (w_evict && r_track && w_tail == r_min);
        n_redo_max = r_redo_max || (w_evict && r_track && w_tail == r_max);
        n_min      = n_redo_min ? n_lo : r_min;
        n_max      = n_redo_max ? n_hi : r_max;
        w_diff     = 33'(n_max) - 33'(n_min);
    end

    swmm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_DIV),
        .i_dividend(r_sum),
        .i_divisor (r_held),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_track     <= 1'b1;
            r_len_cfg   <= LEN_RESET;
            r_held      <= '0;
            r_sum       <= '0;
            r_min       <= MOST_POS;
            r_max       <= MOST_NEG;
            r_spread    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ENABLE: r_enable  <= i_cfg_data[0];
                    REG_TRACK:  r_track   <= i_cfg_data[0];
                    REG_LENGTH: r_len_cfg <= i_cfg_data;
                    default:    ;
                endcase
            end

            // a new result in ST_DONE takes over the output register below
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_acc <= r_enable;
                        if (r_enable) begin
                            r_sum      <= r_sum + w_x;
                            r_max      <= n_max_in;
                            r_min      <= n_min_in;
                            r_h        <= w_h_new;
                            r_len      <= w_eff_len;
                            r_keep     <= (w_h_new > w_eff_len) ? w_eff_len : w_h_new;
                            r_pos      <= POS_W'(RING_SLOTS - 1);
                            r_lo       <= MOST_POS;
                            r_hi       <= MOST_NEG;
                            r_redo_min <= 1'b0;
                            r_redo_max <= 1'b0;
                            r_state    <= ST_ROT;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_ROT: begin
                    r_lo       <= n_lo;
                    r_hi       <= n_hi;
                    r_redo_min <= n_redo_min;
                    r_redo_max <= n_redo_max;
                    if (w_evict) begin
                        r_sum <= r_sum - SUM_W'(w_tail);
                    end
                    r_pos <= r_pos - 1'b1;
                    if (r_pos == '0) begin
                        // pass done, chain is back in place
                        r_held <= r_keep;
                        if (r_track) begin
                            r_min    <= n_min;
                            r_max    <= n_max;
                            r_spread <= (w_diff > 0) ? w_diff[31:0] : 32'd0;
                        end
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    // keep the quotient aside, the output register may still be held
                    if (w_div_done) begin
                        r_mean  <= (r_held == '0) ? '0 : w_quot;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_acc     <= r_acc;
                        r_o_mean    <= r_mean;
                        r_o_min     <= r_min;
                        r_o_max     <= r_max;
                        r_o_spread  <= r_spread;
                        r_o_count   <= 9'(r_held);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_o_acc;
    assign o_mean      = r_o_mean;
    assign o_minimum   = r_o_min;
    assign o_maximum   = r_o_max;
    assign o_spread    = r_o_spread;
    assign o_count     = r_o_count;
endmodule

FILE: src/swmm_checker.sv
// port-level checks for the sliding window block, bound to the top level
// depends on sliding_window_min_max_mean ports only
module swmm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_accepted,
    input logic signed [31:0] o_mean,
    input logic [8:0]        o_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mean))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= 9'd256)
        else $error("count beyond window depth");

    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_count != 9'd0)
        else $error("accepted sample with empty window");

    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count == 9'd0 |-> o_mean == 32'sd0)
        else $error("nonzero mean with empty window");
endmodule

bind sliding_window_min_max_mean swmm_checker u_swmm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_accepted (o_accepted),
    .o_mean     (o_mean),
    .o_count    (o_count)
);
